/* rtl/pol_pkg.sv */
`default_nettype none

package pol_pkg;

    // Field widths
    localparam int KIND_W = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STS_W  = 2;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 6;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam int ENTRIES_DEF = 32;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELLAST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP    = 3'd4;

    // Result status codes
    localparam logic [STS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic apply;       // run the input operation, emit its one result
        logic dump_start;  // clear the dump walk index
        logic dump_beat;   // emit head cell, rotate the used cells
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic dump_last;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/pol_ctrl.sv */
`default_nettype none

module pol_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [pol_pkg::KIND_W-1:0]  i_kind,
    input  wire logic                        i_out_free,
    input  wire pol_pkg::t_sts               i_sts,
    output logic                             o_in_ready,
    output pol_pkg::t_cmd                    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_kind) inside
                        pol_pkg::KIND_APPEND, pol_pkg::KIND_INSERT,
                        pol_pkg::KIND_DELETE, pol_pkg::KIND_DELLAST: begin
                            o_cmd.apply = 1'b1;
                        end
                        pol_pkg::KIND_DUMP: begin
                            if (i_sts.empty) begin
                                o_cmd.apply = 1'b1;
                            end else begin
                                o_cmd.dump_start = 1'b1;
                                n_state          = S_DUMP;
                            end
                        end
                        default: begin
                            // unused kinds: dropped, no result
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (i_out_free) begin
                    o_cmd.dump_beat = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/pol_datapath.sv */
`default_nettype none

module pol_datapath #(
    parameter int ENTRIES = pol_pkg::ENTRIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pol_pkg::t_cmd                     i_cmd,
    input  wire logic [pol_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [pol_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pol_pkg::VAL_W-1:0]  i_value,
    input  wire logic                              i_out_ready,
    output pol_pkg::t_sts                          o_sts,
    output logic                                   o_out_valid,
    output logic [pol_pkg::STS_W-1:0]              o_status,
    output logic signed [pol_pkg::VAL_W-1:0]       o_entry_value,
    output logic [pol_pkg::IDX_W-1:0]              o_entry_index,
    output logic [pol_pkg::CNT_W-1:0]              o_count,
    output logic                                   o_last
);

    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

    logic signed [pol_pkg::VAL_W-1:0] r_cells [ENTRIES];
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [CW-1:0]                    r_idx;

    logic                             r_out_valid;
    logic [pol_pkg::STS_W-1:0]        r_status;
    logic signed [pol_pkg::VAL_W-1:0] r_entry_value;
    logic [pol_pkg::IDX_W-1:0]        r_entry_index;
    logic [pol_pkg::CNT_W-1:0]        r_count_out;
    logic                             r_last;

    logic [CMP_W-1:0]                 w_cnt_x;
    logic [CMP_W-1:0]                 w_pos_x;
    logic [CMP_W-1:0]                 w_idx_p1;
    logic [CMP_W-1:0]                 w_p;
    logic                             w_full;
    logic                             w_ins;
    logic                             w_del;
    logic [pol_pkg::STS_W-1:0]        w_status;

    assign w_cnt_x  = CMP_W'(r_count);
    assign w_pos_x  = CMP_W'(i_position);
    assign w_idx_p1 = CMP_W'(r_idx) + CMP_W'(1);
    assign w_full   = (r_count == CW'(ENTRIES));

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.dump_last = (w_idx_p1 == w_cnt_x);

    // Operation decode: status, shift direction, target cell, new count
    always_comb begin
        w_status = pol_pkg::ST_OK;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_p      = w_pos_x - CMP_W'(1);
        n_count  = r_count;
        case (i_kind)
            pol_pkg::KIND_APPEND: begin
                w_p = w_cnt_x;
                if (w_full) begin
                    w_status = pol_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pol_pkg::KIND_INSERT: begin
                if (w_full) begin
                    w_status = pol_pkg::ST_FULL;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x + CMP_W'(1)) begin
                    w_status = pol_pkg::ST_BADPOS;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pol_pkg::KIND_DELETE: begin
                if (r_count == '0) begin
                    w_status = pol_pkg::ST_EMPTY;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                    w_status = pol_pkg::ST_BADPOS;
                end else begin
                    w_del   = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            pol_pkg::KIND_DELLAST: begin
                if (r_count == '0) begin
                    w_status = pol_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                // dump is applied only on an empty list
                w_status = pol_pkg::ST_EMPTY;
            end
        endcase
    end

    // Each cell looks only at its neighbors, the head cell and the input word
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        localparam logic [CMP_W-1:0] POS = CMP_W'(gi);

        logic signed [pol_pkg::VAL_W-1:0] w_prev;
        logic signed [pol_pkg::VAL_W-1:0] w_next;
        logic signed [pol_pkg::VAL_W-1:0] n_cell;

        if (gi == 0) begin : g_first
            assign w_prev = r_cells[0];
        end else begin : g_mid_prev
            assign w_prev = r_cells[gi-1];
        end
        if (gi == ENTRIES - 1) begin : g_final
            assign w_next = r_cells[gi];
        end else begin : g_mid_next
            assign w_next = r_cells[gi+1];
        end

        always_comb begin
            n_cell = r_cells[gi];
            if (i_cmd.apply && w_ins) begin
                if (POS == w_p) begin
                    n_cell = i_value;
                end else if (POS > w_p) begin
                    n_cell = w_prev;
                end
            end else if (i_cmd.apply && w_del) begin
                if (POS >= w_p) begin
                    n_cell = w_next;
                end
            end else if (i_cmd.dump_beat) begin
                // rotate the used cells left by one; count beats restore order
                if (POS + CMP_W'(1) < w_cnt_x) begin
                    n_cell = w_next;
                end else if (POS + CMP_W'(1) == w_cnt_x) begin
                    n_cell = r_cells[0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cells[gi] <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_count <= n_count;
            end
            if (i_cmd.apply || i_cmd.dump_beat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_start) begin
            r_idx <= '0;
        end else if (i_cmd.dump_beat) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.apply) begin
            r_status      <= w_status;
            r_entry_value <= '0;
            r_entry_index <= '0;
            r_count_out   <= pol_pkg::CNT_W'(n_count);
            r_last        <= 1'b1;
        end else if (i_cmd.dump_beat) begin
            r_status      <= pol_pkg::ST_OK;
            r_entry_value <= r_cells[0];
            r_entry_index <= pol_pkg::IDX_W'(w_idx_p1);
            r_count_out   <= pol_pkg::CNT_W'(r_count);
            r_last        <= o_sts.dump_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry_value;
    assign o_entry_index = r_entry_index;
    assign o_count       = r_count_out;
    assign o_last        = r_last;

endmodule

`default_nettype wire

/* rtl/positional_ordered_list_unit.sv */
// Ordered list of up to ENTRIES signed 32-bit words held in a row of shift
// cells. Each input beat carries one operation in tuser (append, insert at
// a 1-based position, delete at a position, delete last, dump); the unused
// kinds are taken and dropped. Every operation but dump yields one result
// beat with a status and the new count: such beats can follow each other
// every cycle while the output is drained, since all cells shift at once
// and a single output register holds the result. A dump of N entries gives
// N beats after it is accepted, one per cycle while the output drains,
// each read from the head cell while the used cells rotate; no input is
// taken until the last dump beat is in the output register. A dump of an
// empty list gives one beat with status empty. Bad positions, a full list
// and an empty list give an error status and leave the list unchanged.
`default_nettype none

module positional_ordered_list_unit #(
    parameter int ENTRIES = pol_pkg::ENTRIES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // position [5:0], value [37:6], zero fill above
    input  wire logic [pol_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // kind [2:0]
    input  wire logic [pol_pkg::KIND_W-1:0]          i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // status [1:0], entry_value [33:2], entry_index [39:34], count [45:40],
    // zero fill above
    output logic [pol_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    output logic                                     o_m_tlast
);

    localparam int OUT_USED_W = pol_pkg::STS_W + pol_pkg::VAL_W
                              + pol_pkg::IDX_W + pol_pkg::CNT_W;

    pol_pkg::t_cmd                    w_cmd;
    pol_pkg::t_sts                    w_sts;
    logic                             w_out_free;
    logic [pol_pkg::POS_W-1:0]        w_position;
    logic signed [pol_pkg::VAL_W-1:0] w_value;
    logic [pol_pkg::STS_W-1:0]        w_status;
    logic signed [pol_pkg::VAL_W-1:0] w_entry_value;
    logic [pol_pkg::IDX_W-1:0]        w_entry_index;
    logic [pol_pkg::CNT_W-1:0]        w_count;

    assign w_position = i_s_tdata[pol_pkg::POS_W-1:0];
    assign w_value    = i_s_tdata[pol_pkg::POS_W +: pol_pkg::VAL_W];
    assign w_out_free = !o_m_tvalid || i_m_tready;

    pol_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    pol_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_kind        (i_s_tuser),
        .i_position    (w_position),
        .i_value       (w_value),
        .i_out_ready   (i_m_tready),
        .o_sts         (w_sts),
        .o_out_valid   (o_m_tvalid),
        .o_status      (w_status),
        .o_entry_value (w_entry_value),
        .o_entry_index (w_entry_index),
        .o_count       (w_count),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {{(pol_pkg::OUT_TDATA_W - OUT_USED_W){1'b0}},
                        w_count, w_entry_index, w_entry_value, w_status};

endmodule

`default_nettype wire

/* rtl/pol_checker.sv */
`default_nettype none

module pol_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_tvalid,
    input wire logic                                o_s_tready,
    input wire logic [pol_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input wire logic [pol_pkg::KIND_W-1:0]          i_s_tuser,
    input wire logic                                o_m_tvalid,
    input wire logic                                i_m_tready,
    input wire logic [pol_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input wire logic                                o_m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // input is taken only when the output register can take a result
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid || i_m_tready)
        else $error("input ready while output stalled");

    // beats ahead of the last one are dump beats: ok status, nonzero index
    a_dump_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |->
            o_m_tdata[1:0] == pol_pkg::ST_OK && o_m_tdata[39:34] != '0)
        else $error("non-final beat is not a dump entry");

    // error results carry no entry
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != pol_pkg::ST_OK |->
            o_m_tlast && o_m_tdata[33:2] == '0 && o_m_tdata[39:34] == '0)
        else $error("error result carries entry data");

    // no new input while a dump is still streaming
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken during dump");

endmodule

bind positional_ordered_list_unit pol_checker u_pol_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
